// ----- rtl/glyph_outline_bezier_flattener_top_assert.svh -----
// Assertion macros for the outline flattener checker.
`ifndef GLYPH_OUTLINE_BEZIER_FLATTENER_TOP_ASSERT_SVH
`define GLYPH_OUTLINE_BEZIER_FLATTENER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GOBF_ASSERT_IMP(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("flattener assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define GOBF_ASSERT_NXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("flattener assertion failed");

`endif

// ----- rtl/gobf_pkg.sv -----
// Shared types and constants of the outline flattener.
package gobf_pkg;

	localparam int COORD_W    = 24;
	localparam int PT_W       = 32;
	localparam int INV_W      = 19;
	localparam int ACC_W      = 40;
	localparam int MUL_A_W    = 35;
	localparam int PROD_W     = MUL_A_W + INV_W + 1;
	localparam int ROUND_SH   = 17;
	localparam int STEP_W     = 3;
	localparam int PS_W       = 3;
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(7);
	localparam logic [INV_W-1:0]  INV_EM_RESET = INV_W'(16384);

	typedef enum logic [2:0] {
		CMD_MOVE  = 3'd0,
		CMD_LINE  = 3'd1,
		CMD_QUAD  = 3'd2,
		CMD_CUBIC = 3'd3,
		CMD_END   = 3'd4
	} cmd_t;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DECODE = 9'b000000010,
		S_MUL    = 9'b000000100,
		S_RND    = 9'b000001000,
		S_ACT    = 9'b000010000,
		S_EMIT   = 9'b000100000,
		S_NEXT   = 9'b001000000,
		S_CLOSE  = 9'b010000000,
		S_LAST   = 9'b100000000
	} state_t;

	typedef struct packed {
		logic       load;
		logic       init_line;
		logic       init_curve;
		logic       cubic;
		logic       step;
		logic       mul;
		logic       rnd;
		logic       hold_wr;
		logic       hold_idx;
		logic       push;
		logic [1:0] src_k;
		logic       open_at;
		logic       cur_upd;
	} dp_cmd_t;

	typedef struct packed {
		logic push;
		logic fin;
	} ob_cmd_t;

	typedef struct packed {
		logic same;
		logic can_push;
		logic can_fin;
	} ctl_stat_t;

endpackage

// ----- rtl/gobf_obuf.sv -----
// Output stage: one pending point plus the output register.
module gobf_obuf
	import gobf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  ob_cmd_t                ocmd,
	input  logic signed [PT_W-1:0] push_x,
	input  logic signed [PT_W-1:0] push_y,
	input  logic                   push_starts,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic signed [PT_W-1:0] point_x,
	output logic signed [PT_W-1:0] point_y,
	output logic                   starts_contour,
	output logic                   last,
	output logic                   can_push,
	output logic                   can_fin
);

	logic                   pend_v_q, out_v_q;
	logic signed [PT_W-1:0] pend_x_q, pend_y_q;
	logic                   pend_s_q;
	logic                   out_free;

	assign out_free = !out_v_q || out_ready;
	assign can_push = !pend_v_q || out_free;
	assign can_fin  = !pend_v_q || out_free;
	assign out_valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if ((ocmd.push || ocmd.fin) && pend_v_q) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (ocmd.push) begin
				pend_v_q <= 1'b1;
			end else if (ocmd.fin) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((ocmd.push || ocmd.fin) && pend_v_q) begin
			point_x        <= pend_x_q;
			point_y        <= pend_y_q;
			starts_contour <= pend_s_q;
			last           <= ocmd.fin;
		end
		if (ocmd.push) begin
			pend_x_q <= push_x;
			pend_y_q <= push_y;
			pend_s_q <= push_starts;
		end
	end

endmodule

// ----- rtl/gobf_dp.sv -----
// Datapath: coordinates, forward differencing, scaling and held points.
module gobf_dp
	import gobf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   dcmd,
	input  logic                      cfg_we,
	input  logic [INV_W-1:0]          cfg_wdata,
	input  logic signed [COORD_W-1:0] ctrl1_x,
	input  logic signed [COORD_W-1:0] ctrl1_y,
	input  logic signed [COORD_W-1:0] ctrl2_x,
	input  logic signed [COORD_W-1:0] ctrl2_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	output logic signed [PT_W-1:0]    push_x,
	output logic signed [PT_W-1:0]    push_y,
	output logic                      push_starts,
	output logic                      same
);

	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (ROUND_SH - 1);

	logic [INV_W-1:0]          inv_em_q;
	logic signed [COORD_W-1:0] c1_q [2];
	logic signed [COORD_W-1:0] c2_q [2];
	logic signed [COORD_W-1:0] p_q [2];
	logic signed [COORD_W-1:0] cur_q [2];
	logic signed [COORD_W-1:0] first_q [2];
	logic signed [ACC_W-1:0]   s_q [2];
	logic signed [ACC_W-1:0]   d1_q [2];
	logic signed [ACC_W-1:0]   d2_q [2];
	logic signed [ACC_W-1:0]   d3_q [2];
	logic signed [PROD_W-1:0]  prod_s1 [2];
	logic signed [PT_W-1:0]    sc_s2 [2];
	logic signed [PT_W-1:0]    held_q [2][2];
	logic signed [ACC_W-1:0]   qd1 [2];
	logic signed [ACC_W-1:0]   qd2 [2];
	logic signed [ACC_W-1:0]   cd1 [2];
	logic signed [ACC_W-1:0]   cd2 [2];
	logic signed [ACC_W-1:0]   cd3 [2];
	logic signed [PT_W-1:0]    rs [2];

	function automatic logic signed [PT_W-1:0] round_sat(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] q;
		logic                     fits;
		q    = (v + HALF) >>> ROUND_SH;
		fits = (&q[PROD_W-1:PT_W-1]) || !(|q[PROD_W-1:PT_W-1]);
		if (fits) begin
			round_sat = q[PT_W-1:0];
		end else if (q[PROD_W-1]) begin
			round_sat = {1'b1, {(PT_W-1){1'b0}}};
		end else begin
			round_sat = {1'b0, {(PT_W-1){1'b1}}};
		end
	endfunction

	assign same = (cur_q[0] == first_q[0]) && (cur_q[1] == first_q[1]);

	for (genvar k = 0; k < 2; k++) begin : g_lane
		logic signed [ACC_W-1:0] c0, a, b, p, e, bb, cc, dd;
		assign c0 = ACC_W'(cur_q[k]);
		assign a  = ACC_W'(c1_q[k]);
		assign b  = ACC_W'(c2_q[k]);
		assign p  = ACC_W'(p_q[k]);
		// quadratic, weights scaled up by 8 to share the cubic denominator
		assign e      = c0 - (a <<< 1) + p;
		assign qd1[k] = ((a - c0) <<< 7) + (e <<< 3);
		assign qd2[k] = e <<< 4;
		// cubic power-basis coefficients
		assign bb     = (a - c0) * ACC_W'(192);
		assign cc     = (c0 - (a <<< 1) + b) * ACC_W'(24);
		assign dd     = p - c0 + (a - b) * ACC_W'(3);
		assign cd1[k] = bb + cc + dd;
		assign cd2[k] = (cc <<< 1) + dd * ACC_W'(6);
		assign cd3[k] = dd * ACC_W'(6);
		assign rs[k]  = round_sat(prod_s1[k]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_em_q <= INV_EM_RESET;
			for (int k = 0; k < 2; k++) begin
				cur_q[k]   <= '0;
				first_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				inv_em_q <= cfg_wdata;
			end
			for (int k = 0; k < 2; k++) begin
				if (dcmd.open_at) begin
					first_q[k] <= p_q[k];
				end
				if (dcmd.open_at || dcmd.cur_upd) begin
					cur_q[k] <= p_q[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.load) begin
			c1_q[0] <= ctrl1_x;
			c1_q[1] <= ctrl1_y;
			c2_q[0] <= ctrl2_x;
			c2_q[1] <= ctrl2_y;
			p_q[0]  <= end_x;
			p_q[1]  <= end_y;
		end
		for (int k = 0; k < 2; k++) begin
			if (dcmd.init_line || dcmd.init_curve) begin
				s_q[k] <= ACC_W'(cur_q[k]) <<< 9;
			end else if (dcmd.step) begin
				s_q[k] <= s_q[k] + d1_q[k];
			end
			if (dcmd.init_curve) begin
				d1_q[k] <= dcmd.cubic ? cd1[k] : qd1[k];
				d2_q[k] <= dcmd.cubic ? cd2[k] : qd2[k];
				d3_q[k] <= dcmd.cubic ? cd3[k] : '0;
			end else if (dcmd.step) begin
				d1_q[k] <= d1_q[k] + d2_q[k];
				d2_q[k] <= d2_q[k] + d3_q[k];
			end
			if (dcmd.mul) begin
				prod_s1[k] <= $signed(s_q[k][MUL_A_W-1:0]) * $signed({1'b0, inv_em_q});
			end
			if (dcmd.rnd) begin
				sc_s2[k] <= rs[k];
			end
			if (dcmd.hold_wr) begin
				held_q[dcmd.hold_idx][k] <= sc_s2[k];
			end
		end
	end

	always_comb begin
		push_starts = (dcmd.src_k == 2'd0);
		if (dcmd.src_k == 2'd2) begin
			push_x = sc_s2[0];
			push_y = sc_s2[1];
		end else begin
			push_x = held_q[dcmd.src_k[0]][0];
			push_y = held_q[dcmd.src_k[0]][1];
		end
	end

endmodule

// ----- rtl/gobf_ctrl.sv -----
// Controller: command sequencing and contour bookkeeping.
module gobf_ctrl
	import gobf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic [2:0] command,
	input  ctl_stat_t stat,
	output logic      in_ready,
	output dp_cmd_t   dcmd,
	output ob_cmd_t   ocmd
);

	state_t            state_q, state_d;
	logic [2:0]        cmd_q;
	logic              open_q, open_d;
	logic [PS_W-1:0]   ps_q, ps_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              fin_q, fin_d;
	logic [1:0]        k_q, k_d;
	logic              curve;

	assign in_ready = (state_q == S_IDLE);
	assign curve    = (cmd_q == CMD_QUAD) || (cmd_q == CMD_CUBIC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q   <= '0;
			open_q  <= 1'b0;
			ps_q    <= '0;
			step_q  <= '0;
			fin_q   <= 1'b0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			open_q  <= open_d;
			ps_q    <= ps_d;
			step_q  <= step_d;
			fin_q   <= fin_d;
			k_q     <= k_d;
			if (in_valid && in_ready) begin
				cmd_q <= command;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		open_d  = open_q;
		ps_d    = ps_q;
		step_d  = step_q;
		fin_d   = fin_q;
		k_d     = k_q;
		dcmd    = '0;
		dcmd.cubic = (cmd_q == CMD_CUBIC);
		dcmd.src_k = k_q;
		ocmd    = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					dcmd.load = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				fin_d  = 1'b0;
				step_d = '0;
				case (cmd_q)
					CMD_MOVE, CMD_END: begin
						if (open_q) begin
							dcmd.init_line = 1'b1;
							fin_d          = 1'b1;
							state_d        = S_MUL;
						end else begin
							state_d = S_CLOSE;
						end
					end
					CMD_LINE: begin
						if (open_q) begin
							dcmd.init_line = 1'b1;
							state_d        = S_MUL;
						end else begin
							dcmd.open_at = 1'b1;
							open_d       = 1'b1;
							ps_d         = PS_W'(1);
							state_d      = S_LAST;
						end
					end
					CMD_QUAD, CMD_CUBIC: begin
						if (open_q) begin
							dcmd.init_curve = 1'b1;
							state_d         = S_MUL;
						end else begin
							state_d = S_LAST;
						end
					end
					default: state_d = S_LAST;
				endcase
			end
			S_MUL: begin
				dcmd.mul = 1'b1;
				state_d  = S_RND;
			end
			S_RND: begin
				dcmd.rnd = 1'b1;
				state_d  = S_ACT;
			end
			S_ACT: begin
				if (fin_q) begin
					if (ps_q >= PS_W'(4) && !stat.same) begin
						k_d     = 2'd2;
						state_d = S_EMIT;
					end else if (ps_q == PS_W'(3) && !stat.same) begin
						k_d     = 2'd0;
						state_d = S_EMIT;
					end else begin
						state_d = S_CLOSE;
					end
				end else if (ps_q >= PS_W'(4)) begin
					k_d     = 2'd2;
					state_d = S_EMIT;
				end else if (ps_q == PS_W'(3)) begin
					// third point: the contour is long enough, release the held ones
					ps_d    = PS_W'(4);
					k_d     = 2'd0;
					state_d = S_EMIT;
				end else begin
					dcmd.hold_wr  = 1'b1;
					dcmd.hold_idx = ps_q[1];
					ps_d          = ps_q + PS_W'(1);
					state_d       = S_NEXT;
				end
			end
			S_EMIT: begin
				if (stat.can_push) begin
					ocmd.push = 1'b1;
					if (k_q == 2'd2) begin
						state_d = fin_q ? S_CLOSE : S_NEXT;
					end else begin
						k_d = k_q + 2'd1;
					end
				end
			end
			S_NEXT: begin
				if (curve && step_q != STEP_LAST) begin
					dcmd.step = 1'b1;
					step_d    = step_q + STEP_W'(1);
					state_d   = S_MUL;
				end else begin
					dcmd.cur_upd = 1'b1;
					state_d      = S_LAST;
				end
			end
			S_CLOSE: begin
				open_d = 1'b0;
				ps_d   = '0;
				if (cmd_q == CMD_MOVE) begin
					dcmd.open_at = 1'b1;
					open_d       = 1'b1;
					ps_d         = PS_W'(1);
				end
				state_d = S_LAST;
			end
			S_LAST: begin
				if (stat.can_fin) begin
					ocmd.fin = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ----- rtl/glyph_outline_bezier_flattener_top.sv -----
// Outline flattener top level: turns glyph outline commands into contour points.
// Commands (move, line, quadratic, cubic, end) arrive with signed 18.6 pixel
// coordinates and come out as closed contours of signed Q.16 em points, scaled
// by inv_em / 2^17 after a 512x fixed-point weighting, rounded to nearest
// (ties up) and saturated to 32 bits. Curves are flattened into eight points
// each by exact forward differencing of the Bernstein polynomial. The last
// point of a contour is held back and dropped if it repeats the start point,
// and a contour with fewer than three kept points produces nothing. One
// request is worked on at a time and in_ready is high only while idle.
// A line that opens a contour, and a curve, move or end with no open
// contour, scale no point. Others scale each point through the single shared
// multiplier pair (multiply, round, decide, then advance unless the request
// closes its contour), and each point sent out adds an emit step; a line on
// an open contour, or a move or end that closes one, scales one point, and a
// quadratic or cubic eight. The output stage takes one point per cycle while
// the receiver is not stalling; a stalled receiver holds the block in its
// emit and final steps. The "last" flag marks the final point a request
// produces; inv_em is written through cfg_we and cfg_wdata, and the user must
// write it only while the block is idle; the block does not enforce this.
module glyph_outline_bezier_flattener_top
	import gobf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [INV_W-1:0]          cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [2:0]                command,
	input  logic signed [COORD_W-1:0] ctrl1_x,
	input  logic signed [COORD_W-1:0] ctrl1_y,
	input  logic signed [COORD_W-1:0] ctrl2_x,
	input  logic signed [COORD_W-1:0] ctrl2_y,
	input  logic signed [COORD_W-1:0] end_x,
	input  logic signed [COORD_W-1:0] end_y,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [PT_W-1:0]    point_x,
	output logic signed [PT_W-1:0]    point_y,
	output logic                      starts_contour,
	output logic                      last
);

	dp_cmd_t                dcmd;
	ob_cmd_t                ocmd;
	ctl_stat_t              stat;
	logic signed [PT_W-1:0] push_x, push_y;
	logic                   push_starts;
	logic                   same, can_push, can_fin;

	assign stat = '{same: same, can_push: can_push, can_fin: can_fin};

	// sequencing: decode, per-point scale, hold or release points
	gobf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.command  (command),
		.stat     (stat),
		.in_ready (in_ready),
		.dcmd     (dcmd),
		.ocmd     (ocmd)
	);

	// coordinates, differencing, scaling and the held points
	gobf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dcmd        (dcmd),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.ctrl1_x     (ctrl1_x),
		.ctrl1_y     (ctrl1_y),
		.ctrl2_x     (ctrl2_x),
		.ctrl2_y     (ctrl2_y),
		.end_x       (end_x),
		.end_y       (end_y),
		.push_x      (push_x),
		.push_y      (push_y),
		.push_starts (push_starts),
		.same        (same)
	);

	// hold one point back so the final one of a request can carry last
	gobf_obuf u_obuf (
		.clk            (clk),
		.arst_n         (arst_n),
		.ocmd           (ocmd),
		.push_x         (push_x),
		.push_y         (push_y),
		.push_starts    (push_starts),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.point_x        (point_x),
		.point_y        (point_y),
		.starts_contour (starts_contour),
		.last           (last),
		.can_push       (can_push),
		.can_fin        (can_fin)
	);

endmodule

// ----- rtl/gobf_checker.sv -----
// Port-level checker for the outline flattener, bound to the top level.
`include "glyph_outline_bezier_flattener_top_assert.svh"

module gobf_checker
	import gobf_pkg::*;
(
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_we,
	input logic [INV_W-1:0]          cfg_wdata,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic [2:0]                command,
	input logic signed [COORD_W-1:0] ctrl1_x,
	input logic signed [COORD_W-1:0] ctrl1_y,
	input logic signed [COORD_W-1:0] ctrl2_x,
	input logic signed [COORD_W-1:0] ctrl2_y,
	input logic signed [COORD_W-1:0] end_x,
	input logic signed [COORD_W-1:0] end_y,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [PT_W-1:0]    point_x,
	input logic signed [PT_W-1:0]    point_y,
	input logic                      starts_contour,
	input logic                      last
);

	// a stalled point holds
	`GOBF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(point_x) && $stable(point_y) && $stable(starts_contour) && $stable(last))

	// one request at a time: busy right after an accept
	`GOBF_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready)

	// while idle, only the final point of the previous request may still wait
	`GOBF_ASSERT_IMP(a_idle_only_last, in_ready && out_valid, last)

endmodule

bind glyph_outline_bezier_flattener_top gobf_checker u_gobf_checker (.*);
